// ----- design/ldc_pkg.sv -----
`default_nettype none

package ldc_pkg;

    // Number of locks tracked by the lock-order graph (2 to 63).
    localparam int NUM_LOCKS = 40;

    // Width of a lock identifier on the input word.
    localparam int LOCK_W = 6;

    // Bits that index one lock (row or column of the adjacency matrix).
    localparam int IDX_W = $clog2(NUM_LOCKS);

    // Bits that count up to NUM_LOCKS itself (neighbor scan index, stack depth).
    localparam int CNT_W = $clog2(NUM_LOCKS + 1);

    // One search stack frame: node and the next neighbor index to try.
    localparam int FRAME_W = IDX_W + CNT_W;

    typedef struct packed {
        logic [LOCK_W-1:0] lock_id;
        logic              starts_sequence;
    } t_in_word;

    typedef struct packed {
        logic edge_checked;
        logic deadlock;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_ROOT_RD,
        ST_ROOT_CHK,
        ST_SCAN,
        ST_STK_WAIT,
        ST_ROW_WAIT,
        ST_FINISH
    } t_state;

    // What one scan step does with the current neighbor index.
    typedef enum logic [1:0] {
        ACT_SKIP,
        ACT_PUSH,
        ACT_POP,
        ACT_CYCLE
    } t_scan_act;

    typedef struct packed {
        logic accept;
        logic edge_rd;
        logic edge_wr;
        logic search_init;
        logic root_rd;
        logic root_start;
        logic root_next;
        logic scan;
        logic stk_ld;
        logic row_ld;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic      item_is_edge;
        logic      root_skip;
        logic      root_last;
        logic      sp_one;
        t_scan_act scan_act;
        logic      out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- design/ldc_ram.sv -----
`default_nettype none

module ldc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/ldc_dpath.sv -----
`default_nettype none

module ldc_dpath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ldc_pkg::t_in_word  i_in_word,
    input  wire logic               i_out_stall,
    input  wire ldc_pkg::t_dp_cmd   i_cmd,
    output ldc_pkg::t_dp_status     o_status,
    output logic                    o_out_valid,
    output ldc_pkg::t_out_word      o_out_word
);

    localparam int N     = ldc_pkg::NUM_LOCKS;
    localparam int IDX_W = ldc_pkg::IDX_W;
    localparam int CNT_W = ldc_pkg::CNT_W;
    localparam int LW    = ldc_pkg::LOCK_W;

    // Control state.
    logic [LW-1:0]    r_prev_lock;
    logic             r_stopped;
    logic [N-1:0]     r_row_valid;
    logic             r_rd_valid;
    logic [N-1:0]     r_visited;
    logic [N-1:0]     r_on_path;
    logic             r_found;
    logic [IDX_W-1:0] r_root;
    logic [CNT_W-1:0] r_sp;
    logic             r_out_valid;

    // Payload state.
    logic [IDX_W-1:0]   r_edge_row;
    logic [IDX_W-1:0]   r_edge_col;
    logic [IDX_W-1:0]   r_node;
    logic [CNT_W-1:0]   r_j;
    logic [N-1:0]       r_row;
    ldc_pkg::t_out_word r_out_word;

    logic [N-1:0]             adj_rdata;
    logic [N-1:0]             adj_row;
    logic                     adj_re;
    logic [IDX_W-1:0]         adj_raddr;
    logic [N-1:0]             adj_wdata;
    logic [ldc_pkg::FRAME_W-1:0] stk_rdata;
    logic [ldc_pkg::FRAME_W-1:0] stk_wdata;
    logic                     stk_we;
    logic                     stk_re;
    logic [CNT_W-1:0]         sp_m1;
    logic [CNT_W-1:0]         sp_m2;
    logic [IDX_W-1:0]         stk_node;
    logic [CNT_W-1:0]         stk_next;
    logic [IDX_W-1:0]         j_idx;
    logic                     j_end;
    logic                     lock_bad;
    logic                     prev_ok;
    logic                     is_edge;
    ldc_pkg::t_scan_act       scan_act;
    logic                     out_free;
    logic                     out_load;
    ldc_pkg::t_out_word       out_word;

    // A row that was never written reads as empty.
    assign adj_row = r_rd_valid ? adj_rdata : '0;

    assign lock_bad = (i_in_word.lock_id == '0) ||
                      ({1'b0, i_in_word.lock_id} > (LW + 1)'(N));
    assign prev_ok  = (r_prev_lock != '0) && ({1'b0, r_prev_lock} <= (LW + 1)'(N));
    assign is_edge  = !r_stopped && !lock_bad && !i_in_word.starts_sequence && prev_ok;

    assign j_idx = r_j[IDX_W-1:0];
    assign j_end = (r_j == CNT_W'(N));

    always_comb begin
        priority if (j_end) begin
            scan_act = ldc_pkg::ACT_POP;
        end else if (!r_row[j_idx]) begin
            scan_act = ldc_pkg::ACT_SKIP;
        end else if (r_on_path[j_idx]) begin
            scan_act = ldc_pkg::ACT_CYCLE;
        end else if (!r_visited[j_idx]) begin
            scan_act = ldc_pkg::ACT_PUSH;
        end else begin
            scan_act = ldc_pkg::ACT_SKIP;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.item_is_edge = is_edge;
    assign o_status.root_skip    = r_visited[r_root] || (adj_row == '0);
    assign o_status.root_last    = (r_root == IDX_W'(N - 1));
    assign o_status.sp_one       = (r_sp == CNT_W'(1));
    assign o_status.scan_act     = scan_act;
    assign o_status.out_free     = out_free;

    // Adjacency matrix: one row per lock, single read port.
    assign adj_re = i_cmd.edge_rd || i_cmd.root_rd || i_cmd.stk_ld ||
                    (i_cmd.scan && (scan_act == ldc_pkg::ACT_PUSH));

    always_comb begin
        priority if (i_cmd.edge_rd) begin
            adj_raddr = r_edge_row;
        end else if (i_cmd.root_rd) begin
            adj_raddr = r_root;
        end else if (i_cmd.stk_ld) begin
            adj_raddr = stk_node;
        end else begin
            adj_raddr = j_idx;
        end
    end

    assign adj_wdata = adj_row | (N'(1) << r_edge_col);

    ldc_ram #(
        .WIDTH (N),
        .DEPTH (N)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.edge_wr),
        .i_waddr (r_edge_row),
        .i_wdata (adj_wdata),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    // Search stack holds every frame below the top; the top frame is r_node / r_j.
    assign sp_m1     = r_sp - CNT_W'(1);
    assign sp_m2     = r_sp - CNT_W'(2);
    assign stk_we    = i_cmd.scan && (scan_act == ldc_pkg::ACT_PUSH);
    assign stk_re    = i_cmd.scan && (scan_act == ldc_pkg::ACT_POP) && !o_status.sp_one;
    assign stk_wdata = {r_node, r_j + CNT_W'(1)};
    assign stk_node  = stk_rdata[ldc_pkg::FRAME_W-1:CNT_W];
    assign stk_next  = stk_rdata[CNT_W-1:0];

    ldc_ram #(
        .WIDTH (ldc_pkg::FRAME_W),
        .DEPTH (N)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (sp_m1[IDX_W-1:0]),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (sp_m2[IDX_W-1:0]),
        .o_rdata (stk_rdata)
    );

    // Result word: items that add no edge answer at once, edges at the end of the search.
    always_comb begin
        out_load = 1'b0;
        out_word = '0;
        if (i_cmd.accept && !is_edge) begin
            out_load          = 1'b1;
            out_word.deadlock = r_stopped;
        end else if (i_cmd.finish) begin
            out_load              = 1'b1;
            out_word.edge_checked = 1'b1;
            out_word.deadlock     = r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_lock <= '0;
            r_stopped   <= 1'b0;
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
            r_visited   <= '0;
            r_on_path   <= '0;
            r_found     <= 1'b0;
            r_root      <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adj_re) begin
                r_rd_valid <= r_row_valid[adj_raddr];
            end
            if (i_cmd.accept && !r_stopped) begin
                r_prev_lock <= lock_bad ? '0 : i_in_word.lock_id;
            end
            if (i_cmd.edge_wr) begin
                r_row_valid[r_edge_row] <= 1'b1;
            end
            if (i_cmd.search_init) begin
                r_visited <= '0;
                r_on_path <= '0;
                r_found   <= 1'b0;
                r_root    <= '0;
            end
            if (i_cmd.root_next) begin
                r_root <= r_root + IDX_W'(1);
            end
            if (i_cmd.root_start) begin
                r_visited[r_root] <= 1'b1;
                r_on_path[r_root] <= 1'b1;
                r_sp              <= CNT_W'(1);
            end
            if (i_cmd.scan) begin
                unique case (scan_act)
                    ldc_pkg::ACT_PUSH: begin
                        r_visited[j_idx] <= 1'b1;
                        r_on_path[j_idx] <= 1'b1;
                        r_sp             <= r_sp + CNT_W'(1);
                    end
                    ldc_pkg::ACT_POP: begin
                        r_on_path[r_node] <= 1'b0;
                        r_sp              <= sp_m1;
                    end
                    ldc_pkg::ACT_CYCLE: begin
                        r_found <= 1'b1;
                    end
                    ldc_pkg::ACT_SKIP: begin
                    end
                endcase
            end
            if (i_cmd.finish && r_found) begin
                r_stopped <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_edge) begin
            r_edge_row <= IDX_W'(r_prev_lock - LW'(1));
            r_edge_col <= IDX_W'(i_in_word.lock_id - LW'(1));
        end
        if (i_cmd.root_start) begin
            r_node <= r_root;
            r_j    <= '0;
            r_row  <= adj_row;
        end
        if (i_cmd.scan) begin
            if (scan_act == ldc_pkg::ACT_SKIP) begin
                r_j <= r_j + CNT_W'(1);
            end else if (scan_act == ldc_pkg::ACT_PUSH) begin
                r_node <= j_idx;
                r_j    <= '0;
            end
        end
        if (i_cmd.stk_ld) begin
            r_node <= stk_node;
            r_j    <= stk_next;
        end
        if (i_cmd.row_ld) begin
            r_row <= adj_row;
        end
        if (out_load) begin
            r_out_word <= out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ----- design/ldc_ctrl.sv -----
`default_nettype none

module ldc_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire ldc_pkg::t_dp_status i_status,
    output ldc_pkg::t_dp_cmd         o_cmd,
    output logic                     o_in_stall
);

    ldc_pkg::t_state r_state;
    ldc_pkg::t_state n_state;
    logic            take;

    assign take = i_in_valid && i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ldc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ldc_pkg::ST_IDLE: begin
                if (take && i_status.item_is_edge) begin
                    n_state = ldc_pkg::ST_EDGE_RD;
                end
            end
            ldc_pkg::ST_EDGE_RD: begin
                n_state = ldc_pkg::ST_EDGE_WR;
            end
            ldc_pkg::ST_EDGE_WR: begin
                n_state = ldc_pkg::ST_ROOT_RD;
            end
            ldc_pkg::ST_ROOT_RD: begin
                n_state = ldc_pkg::ST_ROOT_CHK;
            end
            ldc_pkg::ST_ROOT_CHK: begin
                if (!i_status.root_skip) begin
                    n_state = ldc_pkg::ST_SCAN;
                end else if (i_status.root_last) begin
                    n_state = ldc_pkg::ST_FINISH;
                end else begin
                    n_state = ldc_pkg::ST_ROOT_RD;
                end
            end
            ldc_pkg::ST_SCAN: begin
                unique case (i_status.scan_act)
                    ldc_pkg::ACT_CYCLE: n_state = ldc_pkg::ST_FINISH;
                    ldc_pkg::ACT_PUSH:  n_state = ldc_pkg::ST_ROW_WAIT;
                    ldc_pkg::ACT_SKIP:  n_state = ldc_pkg::ST_SCAN;
                    ldc_pkg::ACT_POP: begin
                        if (!i_status.sp_one) begin
                            n_state = ldc_pkg::ST_STK_WAIT;
                        end else if (i_status.root_last) begin
                            n_state = ldc_pkg::ST_FINISH;
                        end else begin
                            n_state = ldc_pkg::ST_ROOT_RD;
                        end
                    end
                endcase
            end
            ldc_pkg::ST_STK_WAIT: begin
                n_state = ldc_pkg::ST_ROW_WAIT;
            end
            ldc_pkg::ST_ROW_WAIT: begin
                n_state = ldc_pkg::ST_SCAN;
            end
            ldc_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ldc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ldc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ldc_pkg::ST_IDLE: begin
                o_in_stall   = !i_status.out_free;
                o_cmd.accept = take;
            end
            ldc_pkg::ST_EDGE_RD: begin
                o_cmd.edge_rd = 1'b1;
            end
            ldc_pkg::ST_EDGE_WR: begin
                o_cmd.edge_wr     = 1'b1;
                o_cmd.search_init = 1'b1;
            end
            ldc_pkg::ST_ROOT_RD: begin
                o_cmd.root_rd = 1'b1;
            end
            ldc_pkg::ST_ROOT_CHK: begin
                o_cmd.root_start = !i_status.root_skip;
                o_cmd.root_next  = i_status.root_skip && !i_status.root_last;
            end
            ldc_pkg::ST_SCAN: begin
                o_cmd.scan      = 1'b1;
                o_cmd.root_next = (i_status.scan_act == ldc_pkg::ACT_POP) &&
                                  i_status.sp_one && !i_status.root_last;
            end
            ldc_pkg::ST_STK_WAIT: begin
                o_cmd.stk_ld = 1'b1;
            end
            ldc_pkg::ST_ROW_WAIT: begin
                o_cmd.row_ld = 1'b1;
            end
            ldc_pkg::ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/lock_order_cycle_detector_unit.sv -----
`default_nettype none

// Channel  Direction  Valid        Stall        Word
// -------  ---------  -----------  -----------  ------------------------------------
// in       into block i_in_valid   o_in_stall   i_in_word  (lock_id, starts_sequence)
// out      from block o_out_valid  i_out_stall  o_out_word (edge_checked, deadlock)
//
// A word that adds no edge (stopped, bad lock id, start of a sequence) needs no search.
// A word that adds an edge reads and rewrites the adjacency row (ST_EDGE_RD, ST_EDGE_WR),
// then runs a full depth-first search: each root is read and checked (ST_ROOT_RD,
// ST_ROOT_CHK), ST_SCAN walks a row's neighbor indices one at a time and closes the row,
// a push reloads the row (ST_ROW_WAIT), a pop back to a parent reloads the frame and row
// (ST_STK_WAIT, ST_ROW_WAIT), and ST_FINISH posts the result once the output is free.
// Reset is synchronous and active low; the adjacency rows come up empty through one
// valid flip-flop per row, so no clearing pass is needed.
// A held result waits in the output register; while the sequencer is idle, the next
// word is taken as soon as that register is free or being drained in the same cycle.

module lock_order_cycle_detector_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ldc_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ldc_pkg::t_out_word      o_out_word
);

    // Commands from the sequencer and status back from the datapath.
    ldc_pkg::t_dp_cmd    w_cmd;
    ldc_pkg::t_dp_status w_status;

    // The sequencer walks the edge update and the search, one step per state.
    ldc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the graph memory, search stack, marks and result register.
    ldc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // The adjacency memory has one read port, so at most one reader may use it.
    a_one_reader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.edge_rd, w_cmd.root_rd, w_cmd.stk_ld, w_cmd.scan}))
        else $error("adjacency read port driven by two commands");

    // A search result is posted only when the output register can take it.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> w_status.out_free)
        else $error("search result posted over a held word");

    // A word that adds no edge shows its result in the next cycle.
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.accept && !w_status.item_is_edge) |=> o_out_valid)
        else $error("result of a non-edge word missing");

    // Words are only taken while the input side is not stalled.
    a_accept_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |-> (i_in_valid && !o_in_stall))
        else $error("word taken against the handshake");

endmodule

`default_nettype wire
